// ===== src/dds_pkg.sv =====
// Shared types, codes and constants of the dial sequencer.
package dds_pkg;

  // Store geometry
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned DIG_AW     = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 2);

  // Field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values in milliseconds
  localparam logic [DUR_W-1:0] TONE_MS_RST    = 16'd100;
  localparam logic [DUR_W-1:0] SILENCE_MS_RST = 16'd100;
  localparam logic [DUR_W-1:0] GROUP_MS_RST   = 16'd250;
  localparam logic [DUR_W-1:0] SEQ_MS_RST     = 16'd1000;

  // Fixed pause between digits of one group
  localparam logic [TIME_W-1:0] SHORT_GAP_MS = 32'd50;

  // Characters with a meaning of their own
  localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_START  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_REWIND = 3'd4
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEAVE_OFF = 3'd0,
    ACT_LEAVE_ON  = 3'd1,
    ACT_TURN_ON   = 3'd2,
    ACT_TURN_OFF  = 3'd3,
    ACT_CYCLE_END = 3'd4
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE    = 2'd0,
    CFG_SILENCE = 2'd1,
    CFG_GROUP   = 2'd2,
    CFG_SEQ     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DUR_W-1:0] tone_ms;
    logic [DUR_W-1:0] silence_ms;
    logic [DUR_W-1:0] group_gap_ms;
    logic [DUR_W-1:0] sequence_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] dial_char;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    act_e              action;
    logic [CHAR_W-1:0] current_digit;
    logic              tone_on;
    logic              running;
    logic              store_full;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [DIG_AW-1:0] addr;
    logic [CHAR_W-1:0] data;
  } store_wr_t;

endpackage

// ===== src/dds_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface dds_in_if;
  logic                        valid;
  logic                        ready;
  logic [dds_pkg::CMD_W-1:0]   cmd;
  logic [dds_pkg::CHAR_W-1:0]  dial_char;
  logic [dds_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output cmd, output dial_char, output now_ms, input ready);
  modport sink   (input valid, input cmd, input dial_char, input now_ms, output ready);
endinterface

interface dds_out_if;
  logic                        valid;
  logic                        ready;
  logic [dds_pkg::ACT_W-1:0]   action;
  logic [dds_pkg::CHAR_W-1:0]  current_digit;
  logic                        tone_on;
  logic                        running;
  logic                        store_full;

  modport source (output valid, output action, output current_digit, output tone_on,
                  output running, output store_full, input ready);
  modport sink   (input valid, input action, input current_digit, input tone_on,
                  input running, input store_full, output ready);
endinterface

// ===== src/dds_store.sv =====
// Digit store: register file with one write port and one read port.
module dds_store (
  input  logic                          clk_i,
  input  dds_pkg::store_wr_t            wr_i,
  input  logic [dds_pkg::DIG_AW-1:0]    rd_addr_i,
  output logic [dds_pkg::CHAR_W-1:0]    rd_data_o
);

  logic [dds_pkg::CHAR_W-1:0] mem_q [dds_pkg::MAX_DIGITS];

  // Write the appended character; contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Look up the entry after the play index
  assign rd_data_o = mem_q[rd_addr_i];

endmodule

// ===== src/dds_ctrl.sv =====
// Sequencer state and the per-command update that yields one result.
module dds_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          apply_i,
  input  dds_pkg::item_t                item_i,
  input  dds_pkg::cfg_t                 cfg_i,
  input  logic [dds_pkg::CHAR_W-1:0]    rd_data_i,
  output logic [dds_pkg::DIG_AW-1:0]    rd_addr_o,
  output dds_pkg::store_wr_t            store_wr_o,
  output dds_pkg::result_t              res_o
);

  localparam int unsigned CW = dds_pkg::CNT_W;
  localparam int unsigned TW = dds_pkg::TIME_W;
  localparam int unsigned HW = dds_pkg::CHAR_W;

  localparam logic [CW-1:0] MaxDigits   = CW'(dds_pkg::MAX_DIGITS);
  localparam logic [CW-1:0] IndexLimit  = CW'(dds_pkg::MAX_DIGITS + 1);

  // Phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TONE    = 3'd1;
  localparam logic [2:0] PH_SILENCE = 3'd2;
  localparam logic [2:0] PH_GAP     = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] index_q, index_d;
  logic [2:0]    phase_q, phase_d;
  logic [TW-1:0] event_q, event_d;
  logic          tone_q, tone_d;
  logic          active_q, active_d;
  logic [HW-1:0] cur_q, cur_d;      // store entry at the play index
  logic [HW-1:0] first_q, first_d;  // store entry zero

  logic [CW-1:0] index_p1;
  logic          rd_in_range;
  logic [HW-1:0] ahead_char;
  logic          group_break;
  dds_pkg::act_e action;
  logic          full;

  // Address the entry after the play index
  assign index_p1    = index_q + CW'(1);
  assign rd_in_range = (index_p1 < MaxDigits);
  assign rd_addr_o   = index_p1[dds_pkg::DIG_AW-1:0];
  assign ahead_char  = rd_in_range ? rd_data_i : '0;
  assign group_break = (cur_q == dds_pkg::CHAR_ONE) || (ahead_char == dds_pkg::CHAR_DASH) ||
                       (ahead_char == dds_pkg::CHAR_SPACE);

  // Decode the command and advance the sequence
  always_comb begin
    count_d    = count_q;
    index_d    = index_q;
    phase_d    = phase_q;
    event_d    = event_q;
    tone_d     = tone_q;
    active_d   = active_q;
    cur_d      = cur_q;
    first_d    = first_q;
    action     = dds_pkg::ACT_LEAVE_OFF;
    full       = 1'b0;
    store_wr_o = '0;

    case (item_i.cmd)
      dds_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      dds_pkg::CMD_APPEND: begin
        if (count_q < MaxDigits) begin
          store_wr_o.en   = 1'b1;
          store_wr_o.addr = count_q[dds_pkg::DIG_AW-1:0];
          store_wr_o.data = item_i.dial_char;
          count_d         = count_q + CW'(1);
          if (count_q == index_q) begin
            cur_d = item_i.dial_char;
          end
          if (count_q == '0) begin
            first_d = item_i.dial_char;
          end
        end else begin
          full = 1'b1;
        end
      end
      dds_pkg::CMD_START: begin
        index_d  = '0;
        phase_d  = PH_IDLE;
        event_d  = '0;
        tone_d   = 1'b0;
        active_d = 1'b1;
        cur_d    = first_q;
      end
      dds_pkg::CMD_REWIND: begin
        index_d = '0;
        phase_d = PH_IDLE;
        tone_d  = 1'b0;
        cur_d   = first_q;
      end
      dds_pkg::CMD_STEP: begin
        if (!active_q) begin
          action = dds_pkg::ACT_LEAVE_OFF;
        end else if (item_i.now_ms < event_q) begin
          action = tone_q ? dds_pkg::ACT_LEAVE_ON : dds_pkg::ACT_LEAVE_OFF;
        end else begin
          case (phase_q)
            PH_IDLE: begin
              if (index_q < count_q) begin
                phase_d = PH_TONE;
                tone_d  = 1'b1;
                event_d = item_i.now_ms + TW'(cfg_i.tone_ms);
                action  = dds_pkg::ACT_TURN_ON;
              end else begin
                phase_d = PH_DONE;
                tone_d  = 1'b0;
                event_d = item_i.now_ms + TW'(cfg_i.sequence_gap_ms);
                action  = dds_pkg::ACT_CYCLE_END;
              end
            end
            PH_TONE: begin
              tone_d  = 1'b0;
              phase_d = PH_SILENCE;
              event_d = item_i.now_ms + TW'(cfg_i.silence_ms);
              action  = dds_pkg::ACT_TURN_OFF;
            end
            PH_SILENCE: begin
              if (index_q < IndexLimit) begin
                index_d = index_p1;
                cur_d   = ahead_char;
              end
              if ((index_q < IndexLimit) && (index_p1 < count_q)) begin
                if (group_break) begin
                  phase_d = PH_GAP;
                  event_d = item_i.now_ms + TW'(cfg_i.group_gap_ms);
                end else begin
                  phase_d = PH_IDLE;
                  event_d = item_i.now_ms + dds_pkg::SHORT_GAP_MS;
                end
                action = dds_pkg::ACT_LEAVE_OFF;
              end else begin
                phase_d = PH_DONE;
                event_d = item_i.now_ms + TW'(cfg_i.sequence_gap_ms);
                action  = dds_pkg::ACT_CYCLE_END;
              end
            end
            PH_GAP: begin
              phase_d = PH_IDLE;
              event_d = item_i.now_ms + dds_pkg::SHORT_GAP_MS;
              action  = dds_pkg::ACT_LEAVE_OFF;
            end
            PH_DONE: begin
              active_d = 1'b0;
              tone_d   = 1'b0;
              action   = dds_pkg::ACT_CYCLE_END;
            end
            default: begin
              action = dds_pkg::ACT_LEAVE_OFF;
            end
          endcase
        end
      end
      default: begin
        action = dds_pkg::ACT_LEAVE_OFF;
      end
    endcase

    // Suppress the write when no beat is being applied
    if (!apply_i) begin
      store_wr_o.en = 1'b0;
    end
  end

  // Form the result from the state after the command
  assign res_o.action        = action;
  assign res_o.current_digit = (index_d < count_d) ? cur_d : dds_pkg::CHAR_ZERO;
  assign res_o.tone_on       = tone_d;
  assign res_o.running       = active_d;
  assign res_o.store_full    = full;

  // Commit the state on each applied beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      index_q  <= '0;
      phase_q  <= PH_IDLE;
      event_q  <= '0;
      tone_q   <= 1'b0;
      active_q <= 1'b0;
    end else if (apply_i) begin
      count_q  <= count_d;
      index_q  <= index_d;
      phase_q  <= phase_d;
      event_q  <= event_d;
      tone_q   <= tone_d;
      active_q <= active_d;
    end
  end

  // Hold the cached store entries
  always_ff @(posedge clk_i) begin
    if (apply_i) begin
      cur_q   <= cur_d;
      first_q <= first_d;
    end
  end

endmodule

// ===== src/dtmf_dial_sequencer_unit.sv =====
// Top level of the dial sequencer: channel registers, settings and assertions.
//
// Usage: command beats (cmd, dial_char, now_ms) enter on in_i; every command
// beat yields exactly one result beat (action, current_digit, tone_on,
// running, store_full) on out_o, in order. Settings are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i: index 0 tone, 1 silence, 2 group gap,
// 3 sequence gap, all in milliseconds, taken at the clock edge with the
// enable high.
// Path: an accepted beat waits in the input register until the result register
// is free or being taken, then its result is written into the result register
// and offered on out_o.
// Throughput: one beat per cycle while out_o takes each result; the whole command
// update is one pass of logic between the input register and the result register.
// Reset: sequencer idle and stopped, store empty, settings back to 100, 100,
// 250 and 1000 ms. No clearing pass runs; the store contents are read only
// below the fill count.
// Stall: while out_o is not taken the result register holds, the input
// register still takes one more beat, then in_i ready drops until the
// result moves on.
module dtmf_dial_sequencer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dds_pkg::DUR_W-1:0]         cfg_wdata_i,
  dds_in_if.sink                            in_i,
  dds_out_if.source                         out_o
);

  dds_pkg::cfg_t    cfg_q;
  dds_pkg::item_t   in_q;
  logic             in_valid_q;
  dds_pkg::result_t out_q;
  logic             out_valid_q;
  dds_pkg::result_t res;
  logic             apply;

  dds_pkg::store_wr_t               store_wr;
  logic [dds_pkg::DIG_AW-1:0]       rd_addr;
  logic [dds_pkg::CHAR_W-1:0]       rd_data;

  // Process the held beat when the result register is free
  assign apply      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || apply;

  // Write the settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_ms         <= dds_pkg::TONE_MS_RST;
      cfg_q.silence_ms      <= dds_pkg::SILENCE_MS_RST;
      cfg_q.group_gap_ms    <= dds_pkg::GROUP_MS_RST;
      cfg_q.sequence_gap_ms <= dds_pkg::SEQ_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dds_pkg::CFG_TONE:    cfg_q.tone_ms         <= cfg_wdata_i;
        dds_pkg::CFG_SILENCE: cfg_q.silence_ms      <= cfg_wdata_i;
        dds_pkg::CFG_GROUP:   cfg_q.group_gap_ms    <= cfg_wdata_i;
        dds_pkg::CFG_SEQ:     cfg_q.sequence_gap_ms <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Track input and result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the beat payload and the finished result
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.cmd       <= in_i.cmd;
      in_q.dial_char <= in_i.dial_char;
      in_q.now_ms    <= in_i.now_ms;
    end
    if (apply) begin
      out_q <= res;
    end
  end

  dds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .apply_i    (apply),
    .item_i     (in_q),
    .cfg_i      (cfg_q),
    .rd_data_i  (rd_data),
    .rd_addr_o  (rd_addr),
    .store_wr_o (store_wr),
    .res_o      (res)
  );

  dds_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Drive the result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.action        = out_q.action;
  assign out_o.current_digit = out_q.current_digit;
  assign out_o.tone_on       = out_q.tone_on;
  assign out_o.running       = out_q.running;
  assign out_o.store_full    = out_q.store_full;

`ifndef SYNTHESIS
  // A held beat that cannot move on stays in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !apply |=> in_valid_q)
    else $error("input register lost a beat while blocked");

  // A dropped append never reports a tone action
  a_full_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.store_full |-> out_q.action == dds_pkg::ACT_LEAVE_OFF)
    else $error("store full flagged with a tone action");

  // A tone only sounds while the sequencer runs
  a_tone_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tone_on |-> out_q.running)
    else $error("tone on while sequencer stopped");

  // Turning the tone on leaves the tone flag set
  a_turn_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action == dds_pkg::ACT_TURN_ON |-> out_q.tone_on)
    else $error("turn-on action without tone flag");
`endif

endmodule

// ===== tb/dtmf_dial_sequencer_unit_test.sv =====
// Self-checking testbench of the dial sequencer: directed table, random dial runs, stalls.
`timescale 1ns / 100ps

module dtmf_dial_sequencer_unit_test;

  localparam int unsigned CMD_W      = dds_pkg::CMD_W;
  localparam int unsigned CHAR_W     = dds_pkg::CHAR_W;
  localparam int unsigned TIME_W     = dds_pkg::TIME_W;
  localparam int unsigned DUR_W      = dds_pkg::DUR_W;
  localparam int unsigned CFG_IDX_W  = dds_pkg::CFG_IDX_W;
  localparam int unsigned MAX_DIGITS = dds_pkg::MAX_DIGITS;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RST_CYCLES  = 11;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned HOLD_AT     = 320;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BEATS = 100;
  localparam int unsigned RUN_STEPS   = 60;

  // Command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef enum int unsigned {
    PH_IDLE,
    PH_TONE,
    PH_SILENCE,
    PH_GAP,
    PH_DONE
  } dial_phase_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [TIME_W-1:0] now;
    logic              typed;
    dds_pkg::result_t  want;
  } dial_row_t;

  localparam dds_pkg::result_t NO_RES =
    '{dds_pkg::ACT_LEAVE_OFF, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam dds_pkg::result_t STOPPED_RES =
    '{dds_pkg::ACT_LEAVE_OFF, dds_pkg::CHAR_ZERO, 1'b0, 1'b0, 1'b0};

  // Directed beats: extremes, every command, empty-store run, wrap of event times
  localparam int unsigned DIAL_ROWS = 25;
  localparam dial_row_t dial_table [DIAL_ROWS] = '{
    '{dds_pkg::CMD_STEP,   8'h00, 32'h0000_0000, 1'b1, STOPPED_RES},
    '{CMD_SPARE5,          8'hff, 32'hffff_ffff, 1'b1, STOPPED_RES},
    '{CMD_SPARE6,          8'h00, 32'h0000_0000, 1'b1, STOPPED_RES},
    '{CMD_SPARE7,          8'haa, 32'h5555_5555, 1'b1, STOPPED_RES},
    '{dds_pkg::CMD_REWIND, 8'h55, 32'haaaa_aaaa, 1'b1, STOPPED_RES},
    '{dds_pkg::CMD_CLEAR,  8'hff, 32'hffff_ffff, 1'b1, STOPPED_RES},
    '{dds_pkg::CMD_START,  8'h00, 32'h0000_0000, 1'b1,
      '{dds_pkg::ACT_LEAVE_OFF, dds_pkg::CHAR_ZERO, 1'b0, 1'b1, 1'b0}},
    '{dds_pkg::CMD_STEP,   8'h00, 32'h0000_0000, 1'b1,
      '{dds_pkg::ACT_CYCLE_END, dds_pkg::CHAR_ZERO, 1'b0, 1'b1, 1'b0}},
    '{dds_pkg::CMD_STEP,   8'h00, 32'd999,       1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'd1000,      1'b1,
      '{dds_pkg::ACT_CYCLE_END, dds_pkg::CHAR_ZERO, 1'b0, 1'b0, 1'b0}},
    '{dds_pkg::CMD_STEP,   8'h00, 32'hffff_ffff, 1'b1, STOPPED_RES},
    '{dds_pkg::CMD_APPEND, dds_pkg::CHAR_ONE,   32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_APPEND, 8'h00,               32'hffff_ffff, 1'b0, NO_RES},
    '{dds_pkg::CMD_APPEND, dds_pkg::CHAR_SPACE, 32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_APPEND, 8'hff,               32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_APPEND, dds_pkg::CHAR_DASH,  32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_START,  8'h00, 32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'hffff_fff0, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'hffff_ffff, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'h0000_0063, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'hffff_ffff, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'hffff_ffff, 1'b0, NO_RES},
    '{dds_pkg::CMD_REWIND, 8'h00, 32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_CLEAR,  8'h00, 32'h0000_0000, 1'b0, NO_RES},
    '{dds_pkg::CMD_STEP,   8'h00, 32'h0000_0000, 1'b0, NO_RES}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DUR_W-1:0] cfg_wdata_i;

  dds_in_if  dial_in ();
  dds_out_if dial_out ();

  dtmf_dial_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (dial_in),
    .out_o       (dial_out)
  );

  // Sequencer shadow: timing settings, digit store and playback state
  logic [DUR_W-1:0]  tone_len, sil_len, grp_len, seq_len;
  logic [CHAR_W-1:0] digits [MAX_DIGITS];
  int unsigned       fill_cnt, play_pos;
  dial_phase_e       play_phase;
  logic [TIME_W-1:0] event_at;
  logic              tone_lit, sequencer_on;

  dds_pkg::result_t pending_results [$];
  int unsigned beats_sent;
  int unsigned no_gap_left;
  int unsigned mismatches;
  int unsigned cycles;

  // Clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Advance the playback on a step beat; returns the action code
  function automatic dds_pkg::act_e dial_advance(logic [TIME_W-1:0] now);
    logic [CHAR_W-1:0] prev_c, next_c;
    if (!sequencer_on) return dds_pkg::ACT_LEAVE_OFF;
    if (now < event_at) return tone_lit ? dds_pkg::ACT_LEAVE_ON : dds_pkg::ACT_LEAVE_OFF;
    case (play_phase)
      PH_IDLE: begin
        if (play_pos < fill_cnt) begin
          play_phase = PH_TONE;
          tone_lit   = 1'b1;
          event_at   = now + tone_len;
          return dds_pkg::ACT_TURN_ON;
        end
        play_phase = PH_DONE;
        tone_lit   = 1'b0;
        event_at   = now + seq_len;
        return dds_pkg::ACT_CYCLE_END;
      end
      PH_TONE: begin
        tone_lit   = 1'b0;
        play_phase = PH_SILENCE;
        event_at   = now + sil_len;
        return dds_pkg::ACT_TURN_OFF;
      end
      PH_SILENCE: begin
        if (play_pos < MAX_DIGITS + 1) play_pos++;
        if (play_pos < fill_cnt && play_pos < MAX_DIGITS) begin
          prev_c = digits[play_pos - 1];
          next_c = digits[play_pos];
          // long pause after a one, or ahead of a dash or a space
          if (prev_c == dds_pkg::CHAR_ONE || next_c == dds_pkg::CHAR_DASH ||
              next_c == dds_pkg::CHAR_SPACE) begin
            play_phase = PH_GAP;
            event_at   = now + grp_len;
          end else begin
            play_phase = PH_IDLE;
            event_at   = now + dds_pkg::SHORT_GAP_MS;
          end
          return dds_pkg::ACT_LEAVE_OFF;
        end
        play_phase = PH_DONE;
        event_at   = now + seq_len;
        return dds_pkg::ACT_CYCLE_END;
      end
      PH_GAP: begin
        play_phase = PH_IDLE;
        event_at   = now + dds_pkg::SHORT_GAP_MS;
        return dds_pkg::ACT_LEAVE_OFF;
      end
      PH_DONE: begin
        sequencer_on = 1'b0;
        tone_lit     = 1'b0;
        return dds_pkg::ACT_CYCLE_END;
      end
      default: return dds_pkg::ACT_LEAVE_OFF;
    endcase
  endfunction

  // Apply one command beat to the shadow and work out its result
  function automatic dds_pkg::result_t dial_step(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                                 logic [TIME_W-1:0] now);
    dds_pkg::result_t res;
    res = NO_RES;
    case (cmd)
      dds_pkg::CMD_CLEAR: fill_cnt = 0;
      dds_pkg::CMD_APPEND: begin
        if (fill_cnt < MAX_DIGITS) begin
          digits[fill_cnt] = ch;
          fill_cnt++;
        end else begin
          res.store_full = 1'b1;
        end
      end
      dds_pkg::CMD_START: begin
        play_pos     = 0;
        play_phase   = PH_IDLE;
        event_at     = '0;
        tone_lit     = 1'b0;
        sequencer_on = 1'b1;
      end
      dds_pkg::CMD_STEP: res.action = dial_advance(now);
      dds_pkg::CMD_REWIND: begin
        play_pos   = 0;
        play_phase = PH_IDLE;
        tone_lit   = 1'b0;
      end
      default: ;
    endcase
    res.current_digit = (play_pos < fill_cnt && play_pos < MAX_DIGITS) ? digits[play_pos]
                                                                        : dds_pkg::CHAR_ZERO;
    res.tone_on = tone_lit;
    res.running = sequencer_on;
    return res;
  endfunction

  // Offer one command beat after a random gap, and queue its expected result once taken
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch, logic [TIME_W-1:0] now,
                           logic typed = 1'b0, dds_pkg::result_t fixed = NO_RES);
    int unsigned      gap, r;
    dds_pkg::result_t want;
    gap = 0;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) no_gap_left = 40;
      else if (r < 70) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      dial_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dial_in.valid     <= 1'b1;
    dial_in.cmd       <= cmd;
    dial_in.dial_char <= ch;
    dial_in.now_ms    <= now;
    do @(posedge clk_i); while (dial_in.ready !== 1'b1);
    want = dial_step(cmd, ch, now);
    if (typed) want = fixed;
    pending_results.push_back(want);
    beats_sent++;
  endtask

  // Drop valid and wait for every result to come back
  task automatic park_sender();
    dial_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(dds_pkg::cfg_idx_e idx, logic [DUR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      dds_pkg::CFG_TONE:    tone_len = value;
      dds_pkg::CFG_SILENCE: sil_len  = value;
      dds_pkg::CFG_GROUP:   grp_len  = value;
      dds_pkg::CFG_SEQ:     seq_len  = value;
      default: ;
    endcase
  endtask

  task automatic program_timing(dds_pkg::cfg_t s);
    write_reg(dds_pkg::CFG_TONE, s.tone_ms);
    write_reg(dds_pkg::CFG_SILENCE, s.silence_ms);
    write_reg(dds_pkg::CFG_GROUP, s.group_gap_ms);
    write_reg(dds_pkg::CFG_SEQ, s.sequence_gap_ms);
    cfg_we_i <= 1'b0;
  endtask

  // Favour the characters that shape the pauses
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return dds_pkg::CHAR_ONE;
    if (r < 45) return dds_pkg::CHAR_DASH;
    if (r < 60) return dds_pkg::CHAR_SPACE;
    return CHAR_W'($urandom);
  endfunction

  // One well-formed dial run: clear, fill, start, then steps near the event times
  task automatic dial_run();
    int unsigned       n, steps, r;
    logic [TIME_W-1:0] t;
    send_beat(dds_pkg::CMD_CLEAR, CHAR_W'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 5);
    else if (r < 90) n = $urandom_range(6, 12);
    else n = $urandom_range(MAX_DIGITS - 4, MAX_DIGITS + 4);
    repeat (n) send_beat(dds_pkg::CMD_APPEND, pick_char(), $urandom);
    send_beat(dds_pkg::CMD_START, CHAR_W'($urandom), $urandom);
    // first step sets the time base: low, just under the wrap, or anywhere
    case ($urandom_range(0, 2))
      0:       t = $urandom_range(0, 500);
      1:       t = 32'hffff_ffff - $urandom_range(0, 3000);
      default: t = $urandom;
    endcase
    send_beat(dds_pkg::CMD_STEP, CHAR_W'($urandom), t);
    steps = 0;
    while (sequencer_on && steps < RUN_STEPS) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // disturb the run with an out-of-turn command
        case ($urandom_range(0, 5))
          0: send_beat(dds_pkg::CMD_REWIND, CHAR_W'($urandom), $urandom);
          1: send_beat(dds_pkg::CMD_CLEAR, CHAR_W'($urandom), $urandom);
          2: send_beat(dds_pkg::CMD_APPEND, pick_char(), $urandom);
          3: send_beat(dds_pkg::CMD_START, CHAR_W'($urandom), $urandom);
          4: send_beat(CMD_SPARE5 + CMD_W'($urandom_range(0, 2)), CHAR_W'($urandom),
                       $urandom);
          default: send_beat(dds_pkg::CMD_STEP, CHAR_W'($urandom), $urandom);
        endcase
      end else begin
        if (r < 70) t = event_at + $urandom_range(0, 3);
        else if (r < 82) t = event_at;
        else if (r < 92) t = event_at - 1 - $urandom_range(0, 20);
        else t = $urandom;
        send_beat(dds_pkg::CMD_STEP, CHAR_W'($urandom), t);
      end
      steps++;
    end
  endtask

  // Result sink: random stalls, stretches without any, and one long hold-off
  initial begin : result_sink
    int unsigned r, run;
    bit          held;
    held = 1'b0;
    dial_out.ready <= 1'b0;
    forever begin
      if (!held && beats_sent >= HOLD_AT) begin
        held = 1'b1;
        dial_out.ready <= 1'b0;
        for (int unsigned c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          dial_out.ready <= 1'b1;
          run = $urandom_range(1, 8);
        end else if (r < 85) begin
          dial_out.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else if (r < 93) begin
          dial_out.ready <= 1'b0;
          run = $urandom_range(8, 40);
        end else begin
          dial_out.ready <= 1'b1;
          run = $urandom_range(50, 150);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    dds_pkg::result_t got, want;
    if (rst_ni && dial_out.valid === 1'b1 && dial_out.ready === 1'b1) begin
      got.action        = dds_pkg::act_e'(dial_out.action);
      got.current_digit = dial_out.current_digit;
      got.tone_on       = dial_out.tone_on;
      got.running       = dial_out.running;
      got.store_full    = dial_out.store_full;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.action !== want.action) report_mismatch("action", got.action, want.action);
        if (got.current_digit !== want.current_digit)
          report_mismatch("current_digit", got.current_digit, want.current_digit);
        if (got.tone_on !== want.tone_on)
          report_mismatch("tone_on", got.tone_on, want.tone_on);
        if (got.running !== want.running)
          report_mismatch("running", got.running, want.running);
        if (got.store_full !== want.store_full)
          report_mismatch("store_full", got.store_full, want.store_full);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    dds_pkg::cfg_t timing;
    mismatches   = 0;
    beats_sent   = 0;
    no_gap_left  = 0;
    tone_len     = dds_pkg::TONE_MS_RST;
    sil_len      = dds_pkg::SILENCE_MS_RST;
    grp_len      = dds_pkg::GROUP_MS_RST;
    seq_len      = dds_pkg::SEQ_MS_RST;
    fill_cnt     = 0;
    play_pos     = 0;
    play_phase   = PH_IDLE;
    event_at     = '0;
    tone_lit     = 1'b0;
    sequencer_on = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= dds_pkg::CFG_TONE;
    cfg_wdata_i       <= '0;
    dial_in.valid     <= 1'b0;
    dial_in.cmd       <= dds_pkg::CMD_CLEAR;
    dial_in.dial_char <= '0;
    dial_in.now_ms    <= '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    // Walk the directed table with the reset timing
    for (int unsigned i = 0; i < DIAL_ROWS; i++)
      send_beat(dial_table[i].cmd, dial_table[i].ch, dial_table[i].now,
                dial_table[i].typed, dial_table[i].want);

    // Random dial runs under a series of timing settings
    for (int unsigned p = 0; p < 6; p++) begin
      park_sender();
      case (p)
        0: timing = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        1: timing = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        2: timing = '{16'd1, 16'd2, 16'd3, 16'd4};
        3: timing = '{DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom)};
        4: timing = '{dds_pkg::TONE_MS_RST, dds_pkg::SILENCE_MS_RST,
                      dds_pkg::GROUP_MS_RST, dds_pkg::SEQ_MS_RST};
        default: timing = '{DUR_W'($urandom_range(0, 300)), DUR_W'($urandom_range(0, 300)),
                             DUR_W'($urandom_range(0, 300)), DUR_W'($urandom_range(0, 300))};
      endcase
      program_timing(timing);
      while (beats_sent < DIAL_ROWS + (p + 1) * PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 85) begin
          dial_run();
        end else begin
          // noise: any code, any byte, any time
          repeat ($urandom_range(1, 6))
            send_beat(CMD_W'($urandom_range(0, 7)), CHAR_W'($urandom), $urandom);
        end
      end
    end

    park_sender();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dds_pkg.sv
src/dds_if.sv
src/dds_store.sv
src/dds_ctrl.sv
src/dtmf_dial_sequencer_unit.sv
tb/dtmf_dial_sequencer_unit_test.sv
